### sv/ebrp_pkg.sv
// Shared types, byte codes and helper functions for the board record parser.
// No dependencies; imported by eeprom_board_record_parser.
package ebrp_pkg;

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_NL    = 8'h0A;
   localparam logic [7:0] BYTE_FF    = 8'hFF;
   localparam logic [7:0] BYTE_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_E     = 8'h45;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_H     = 8'h48;
   localparam logic [7:0] CHAR_Z     = 8'h5A;

   localparam logic [7:0] BUS_LIMIT_RESET = 8'd50;
   localparam logic [3:0] HEX_DIGITS      = 4'd12;
   localparam int         DIV_STEPS       = 32;

   typedef enum logic [2:0] {
      PH_TAG1  = 3'd0,
      PH_TAG2  = 3'd1,
      PH_SEP   = 3'd2,
      PH_VALUE = 3'd3,
      PH_SKIP  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      KIND_EA   = 3'd0,
      KIND_SB   = 3'd1,
      KIND_D1   = 3'd2,
      KIND_HZ   = 3'd3,
      KIND_END  = 3'd4,
      KIND_NONE = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      FRZ_ACC  = 2'd0,
      FRZ_DEN  = 2'd1,
      FRZ_HOLD = 2'd2
   } frozen_type;

   typedef enum logic [1:0] {
      SEQ_IDLE = 2'd0,
      SEQ_DIV  = 2'd1,
      SEQ_MUL  = 2'd2,
      SEQ_FIN  = 2'd3
   } seq_type;

   // Hex character to nibble; anything else counts as zero.
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      begin
         d = 8'h00;
         if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
         end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
         end else if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
         end
         return d[3:0];
      end
   endfunction

   // acc * 10 + (b - '0'), wrapping at 32 bits.
   function automatic logic [31:0] dec_push(input logic [31:0] acc, input logic [7:0] b);
      begin
         return {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {24'h000000, b}
                - {24'h000000, CHAR_ZERO};
      end
   endfunction

endpackage

### sv/eeprom_board_record_parser.sv
// Board record parser: turns a board-information EEPROM image into records.
// Depends on ebrp_pkg for types, byte codes and the digit helpers.
//
//  Channel  Direction  Beat contents
//  req_     in         tdata[7:0] data_byte; tuser image_start
//  rsp_     out        tdata[47:0] record_value, [79:48] bus_frequency;
//                      tuser record_kind
//  csr_     in         wdata = bus_limit_mhz, written when csr_we is high
//
// Every record except a CPU speed record is finished in the cycle its
// terminating byte is taken. A CPU speed record then loads the result from
// the FIN state once the output register is free; with a denominator the
// shared restoring divider first runs (one quotient bit per cycle) and then
// multiplies back in the MUL state. The input is not ready during that work,
// nor while an undelivered result blocks the output register. Reset is
// synchronous and clears the parser and sets the limit to 50.
module eeprom_board_record_parser
   import ebrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] image_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [47:0] record_value, [79:48] bus_frequency
   output logic [2:0]  rsp_tuser,   // [2:0] record_kind
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   // Parser state.
   phase_type   phase_ff, phase_in;
   logic [7:0]  first_ff, first_in;
   kind_type    kind_ff, kind_in;
   logic [31:0] dec_ff, dec_in;
   logic [47:0] addr_ff, addr_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  den_ff, den_in;
   frozen_type  frz_ff, frz_in;
   logic        nl_ff, nl_in;
   logic        done_ff, done_in;
   logic [7:0]  limit_ff, limit_in;

   // Shared divider and sequencer.
   seq_type     seq_ff, seq_in;
   logic [31:0] div_num_ff, div_num_in;
   logic [3:0]  div_rem_ff, div_rem_in;
   logic [3:0]  div_den_ff, div_den_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff, rsp_kind_in;
   logic [47:0] rsp_value_ff, rsp_value_in;
   logic [31:0] rsp_bus_ff, rsp_bus_in;

   // State as seen by the current byte, after an image start clears it.
   phase_type   cur_phase;
   logic [7:0]  cur_first;
   kind_type    cur_kind;
   logic [31:0] cur_dec;
   logic [47:0] cur_addr;
   logic [3:0]  cur_cnt;
   logic [3:0]  cur_den;
   frozen_type  cur_frz;
   logic        cur_nl;
   logic        cur_done;

   logic        byte_acc;
   logic        out_free;
   logic [7:0]  b;
   logic        is_term;
   logic        emit_now;
   logic        emit_hz;
   kind_type    emit_kind;
   logic [47:0] emit_value;
   logic [5:0]  ea_shift;
   logic [31:0] sb_value;
   logic [4:0]  div_trial;
   logic        div_fit;
   logic        fin_load;
   logic [31:0] fin_bus;

   assign b        = req_tdata;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign byte_acc = req_tvalid && req_tready;
   assign is_term  = (b == BYTE_NL) || (b == BYTE_FF);

   assign cur_phase = req_tuser ? PH_TAG1   : phase_ff;
   assign cur_first = req_tuser ? 8'h00     : first_ff;
   assign cur_kind  = req_tuser ? KIND_NONE : kind_ff;
   assign cur_dec   = req_tuser ? 32'd0     : dec_ff;
   assign cur_addr  = req_tuser ? 48'd0     : addr_ff;
   assign cur_cnt   = req_tuser ? 4'd0      : cnt_ff;
   assign cur_den   = req_tuser ? 4'd0      : den_ff;
   assign cur_frz   = req_tuser ? FRZ_ACC   : frz_ff;
   assign cur_nl    = req_tuser ? 1'b0      : nl_ff;
   assign cur_done  = req_tuser ? 1'b0      : done_ff;

   // Missing address digits are zeros on the right: shift by four per digit.
   assign ea_shift = {HEX_DIGITS - cur_cnt, 2'b00};
   // acc * 100 as 64 + 32 + 4 times acc.
   assign sb_value = {cur_dec[25:0], 6'b0} + {cur_dec[26:0], 5'b0} + {cur_dec[29:0], 2'b0};

   // Per-byte parser update. It only looks at the byte when it is accepted.
   always_comb begin
      phase_in   = phase_ff;
      first_in   = first_ff;
      kind_in    = kind_ff;
      dec_in     = dec_ff;
      addr_in    = addr_ff;
      cnt_in     = cnt_ff;
      den_in     = den_ff;
      frz_in     = frz_ff;
      nl_in      = nl_ff;
      done_in    = done_ff;
      emit_now   = 1'b0;
      emit_hz    = 1'b0;
      emit_kind  = KIND_END;
      emit_value = 48'd0;
      if (byte_acc) begin
         phase_in = cur_phase;
         first_in = cur_first;
         kind_in  = cur_kind;
         dec_in   = cur_dec;
         addr_in  = cur_addr;
         cnt_in   = cur_cnt;
         den_in   = cur_den;
         frz_in   = cur_frz;
         nl_in    = cur_nl;
         done_in  = cur_done;
         if (!cur_done) begin
            if (cur_phase == PH_TAG1 && cur_nl && (b == BYTE_NUL || b == BYTE_FF)) begin
               // A blank record right after a terminator ends the table.
               done_in   = 1'b1;
               nl_in     = 1'b0;
               emit_now  = 1'b1;
               emit_kind = KIND_END;
            end else if (is_term) begin
               if (cur_phase == PH_SEP || cur_phase == PH_VALUE) begin
                  case (cur_kind)
                     KIND_EA: begin
                        emit_now   = 1'b1;
                        emit_kind  = KIND_EA;
                        emit_value = cur_addr << ea_shift;
                     end
                     KIND_SB: begin
                        emit_now   = 1'b1;
                        emit_kind  = KIND_SB;
                        emit_value = {16'h0000, sb_value};
                     end
                     KIND_D1: begin
                        emit_now   = 1'b1;
                        emit_kind  = KIND_D1;
                        emit_value = {16'h0000, cur_dec[11:0], 20'h00000};
                     end
                     KIND_HZ: emit_hz = 1'b1;
                     default: emit_now = 1'b0;
                  endcase
               end
               phase_in = PH_TAG1;
               first_in = 8'h00;
               kind_in  = KIND_NONE;
               dec_in   = 32'd0;
               addr_in  = 48'd0;
               cnt_in   = 4'd0;
               den_in   = 4'd0;
               frz_in   = FRZ_ACC;
               nl_in    = 1'b1;
            end else begin
               nl_in = 1'b0;
               case (cur_phase)
                  PH_TAG1: begin
                     if (b == CHAR_E || b == CHAR_S || b == CHAR_D || b == CHAR_H) begin
                        first_in = b;
                        phase_in = PH_TAG2;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_TAG2: begin
                     phase_in = PH_SEP;
                     if (cur_first == CHAR_E && b == CHAR_A) begin
                        kind_in = KIND_EA;
                     end else if (cur_first == CHAR_S && b == CHAR_B) begin
                        kind_in = KIND_SB;
                     end else if (cur_first == CHAR_D && b == CHAR_ONE) begin
                        kind_in = KIND_D1;
                     end else if (cur_first == CHAR_H && b == CHAR_Z) begin
                        kind_in = KIND_HZ;
                     end else begin
                        kind_in  = KIND_NONE;
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_SEP: phase_in = PH_VALUE;
                  PH_VALUE: begin
                     case (cur_kind)
                        KIND_EA: begin
                           if (cur_cnt < HEX_DIGITS) begin
                              addr_in = {cur_addr[43:0], hex_value(b)};
                              cnt_in  = cur_cnt + 4'd1;
                           end
                        end
                        KIND_SB, KIND_D1: dec_in = dec_push(cur_dec, b);
                        KIND_HZ: begin
                           if (cur_frz == FRZ_ACC) begin
                              // The slash only counts once a value byte was seen.
                              if (cur_cnt != 4'd0 && b == BYTE_SLASH) begin
                                 frz_in = FRZ_DEN;
                              end else begin
                                 dec_in = dec_push(cur_dec, b);
                                 cnt_in = 4'd1;
                              end
                           end else if (cur_frz == FRZ_DEN) begin
                              den_in = (b >= CHAR_ZERO && b <= CHAR_NINE) ?
                                       4'(b - CHAR_ZERO) : 4'd0;
                              frz_in = FRZ_HOLD;
                           end
                        end
                        default: dec_in = cur_dec;
                     endcase
                  end
                  default: phase_in = cur_phase;
               endcase
            end
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      seq_in = seq_ff;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (emit_hz) begin
               seq_in = (cur_den == 4'd0) ? SEQ_FIN : SEQ_DIV;
            end
         end
         SEQ_DIV: begin
            if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
               seq_in = SEQ_MUL;
            end
         end
         SEQ_MUL: seq_in = SEQ_FIN;
         SEQ_FIN: begin
            if (out_free) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   // One restoring-division step: bring down the next dividend bit.
   assign div_trial = {div_rem_ff, div_num_ff[31]};
   assign div_fit   = div_trial >= {1'b0, div_den_ff};
   assign fin_bus   = (div_num_ff > {24'h000000, limit_ff}) ? {1'b0, div_num_ff[31:1]}
                                                             : div_num_ff;

   // Sequencer outputs and datapath.
   always_comb begin
      req_tready = (seq_ff == SEQ_IDLE) && out_free;
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      fin_load   = 1'b0;
      unique case (seq_ff)
         SEQ_IDLE: begin
            if (emit_hz) begin
               div_num_in = cur_dec;
               div_rem_in = 4'd0;
               div_den_in = cur_den;
               div_cnt_in = 5'd0;
            end
         end
         SEQ_DIV: begin
            div_num_in = {div_num_ff[30:0], div_fit};
            div_rem_in = div_fit ? 4'(div_trial - {1'b0, div_den_ff}) : div_trial[3:0];
            div_cnt_in = div_cnt_ff + 5'd1;
         end
         SEQ_MUL: div_num_in = 32'(div_num_ff * {28'h0000000, div_den_ff});
         SEQ_FIN: fin_load = out_free;
         default: fin_load = 1'b0;
      endcase
   end

   // Output register: loaded from the parser or from the speed path.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_bus_in   = rsp_bus_ff;
      if (emit_now) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_value_in = emit_value;
         rsp_bus_in   = 32'd0;
      end else if (fin_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_HZ;
         rsp_value_in = {16'h0000, div_num_ff};
         rsp_bus_in   = fin_bus;
      end
   end

   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG1;
         first_ff     <= 8'h00;
         kind_ff      <= KIND_NONE;
         dec_ff       <= 32'd0;
         addr_ff      <= 48'd0;
         cnt_ff       <= 4'd0;
         den_ff       <= 4'd0;
         frz_ff       <= FRZ_ACC;
         nl_ff        <= 1'b0;
         done_ff      <= 1'b0;
         limit_ff     <= BUS_LIMIT_RESET;
         seq_ff       <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         kind_ff      <= kind_in;
         dec_ff       <= dec_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         den_ff       <= den_in;
         frz_ff       <= frz_in;
         nl_ff        <= nl_in;
         done_ff      <= done_in;
         limit_ff     <= limit_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      div_den_ff   <= div_den_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_bus_ff   <= rsp_bus_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_bus_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

### test/testbench.sv
// Self-checking testbench for the board record parser: stream beats in, records out.
// Depends on ebrp_pkg for byte codes and kinds, and on eeprom_board_record_parser.
`timescale 1ns / 100ps

module testbench
   import ebrp_pkg::*;
();

   localparam int          RESET_CYCLES = 11;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 40;   // time for a divided clock record to finish
   localparam int          HOLD_CYCLES  = 600;
   localparam int          CHUNK_BYTES  = 180;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;

   // One expected output beat.
   typedef struct packed {
      kind_type    kind;
      logic [47:0] value;
      logic [31:0] bus;
   } board_record_type;

   // Tracks the parser state byte by byte and keeps the records it must emit.
   class record_tracker_type;
      logic [7:0]       bus_limit;
      phase_type        phase;
      logic [7:0]       tag_first;
      kind_type         kind;
      logic [31:0]      dec_acc;
      logic [47:0]      mac_acc;
      logic [3:0]       digits_seen;
      logic [3:0]       divisor;
      frozen_type       frozen;
      bit               line_start;
      bit               table_ended;
      board_record_type expected_records[$];
      int               errors;

      function new();
         bus_limit = BUS_LIMIT_RESET;
         errors = 0;
         restart();
      endfunction

      function void clear_record();
         phase = PH_TAG1;
         tag_first = 8'h00;
         kind = KIND_NONE;
         dec_acc = '0;
         mac_acc = '0;
         digits_seen = '0;
         divisor = '0;
         frozen = FRZ_ACC;
      endfunction

      function void restart();
         clear_record();
         line_start = 0;
         table_ended = 0;
      endfunction

      function logic [31:0] push_digit(logic [31:0] acc, logic [7:0] b);
         return acc * 32'd10 + {24'd0, b} - {24'd0, CHAR_ZERO};
      endfunction

      // Called at a terminator; queues a record for a recognized tag.
      function void close_record();
         board_record_type r;
         logic [31:0]      num;
         r.kind = kind;
         r.value = '0;
         r.bus = '0;
         case (kind)
            KIND_EA: r.value = mac_acc << (4 * (12 - digits_seen));
            KIND_SB: begin
               num = dec_acc * 32'd100;
               r.value = {16'd0, num};
            end
            KIND_D1: begin
               num = dec_acc << 20;
               r.value = {16'd0, num};
            end
            KIND_HZ: begin
               num = dec_acc;
               if (divisor != 0) num = (num / divisor) * divisor;
               r.bus = (num > {24'd0, bus_limit}) ? (num >> 1) : num;
               r.value = {16'd0, num};
            end
            default: return;
         endcase
         expected_records.push_back(r);
      endfunction

      // Takes one accepted input beat. Returns 0 when the byte is ignored because
      // the table has already ended.
      function bit take_byte(logic [7:0] b, bit image_start);
         logic [3:0] nib;
         logic [7:0] d8;
         if (image_start) restart();
         if (table_ended) return 0;

         // A NUL or 0xFF right after a terminator closes the table.
         if (phase == PH_TAG1 && line_start && (b == BYTE_NUL || b == BYTE_FF)) begin
            table_ended = 1;
            line_start = 0;
            expected_records.push_back('{KIND_END, 48'd0, 32'd0});
            return 1;
         end
         line_start = 0;

         if (b == BYTE_NL || b == BYTE_FF) begin
            // Only a record that got past its tag produces anything.
            if (phase == PH_SEP || phase == PH_VALUE) close_record();
            clear_record();
            line_start = 1;
            return 1;
         end

         case (phase)
            PH_TAG1: begin
               if (b inside {CHAR_E, CHAR_S, CHAR_D, CHAR_H}) begin
                  tag_first = b;
                  phase = PH_TAG2;
               end else begin
                  phase = PH_SKIP;
               end
            end
            PH_TAG2: begin
               if (tag_first == CHAR_E && b == CHAR_A) kind = KIND_EA;
               else if (tag_first == CHAR_S && b == CHAR_B) kind = KIND_SB;
               else if (tag_first == CHAR_D && b == CHAR_ONE) kind = KIND_D1;
               else if (tag_first == CHAR_H && b == CHAR_Z) kind = KIND_HZ;
               else kind = KIND_NONE;
               phase = (kind == KIND_NONE) ? PH_SKIP : PH_SEP;
            end
            PH_SEP: phase = PH_VALUE;
            PH_VALUE: begin
               case (kind)
                  KIND_EA: begin
                     if (digits_seen < HEX_DIGITS) begin
                        nib = 4'd0;
                        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                           d8 = b - CHAR_ZERO;
                           nib = d8[3:0];
                        end else if (b >= CHAR_A && b <= CHAR_A + 8'd5) begin
                           d8 = b - CHAR_A + 8'd10;
                           nib = d8[3:0];
                        end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_A + 8'd5) begin
                           d8 = b - CHAR_LOWER_A + 8'd10;
                           nib = d8[3:0];
                        end
                        mac_acc = {mac_acc[43:0], nib};
                        digits_seen = digits_seen + 4'd1;
                     end
                  end
                  KIND_SB, KIND_D1: dec_acc = push_digit(dec_acc, b);
                  KIND_HZ: begin
                     // digits_seen only flags that the numerator has started here.
                     if (frozen == FRZ_ACC) begin
                        if (digits_seen != 0 && b == BYTE_SLASH) begin
                           frozen = FRZ_DEN;
                        end else begin
                           dec_acc = push_digit(dec_acc, b);
                           digits_seen = 4'd1;
                        end
                     end else if (frozen == FRZ_DEN) begin
                        d8 = b - CHAR_ZERO;
                        divisor = (b >= CHAR_ZERO && b <= CHAR_NINE) ? d8[3:0] : 4'd0;
                        frozen = FRZ_HOLD;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         return 1;
      endfunction

      function void check_record(logic [2:0] k, logic [47:0] v, logic [31:0] f);
         board_record_type e;
         if (expected_records.size() == 0) begin
            $display("%0t: unexpected record kind %0d value %h bus %h", $time, k, v, f);
            errors++;
            return;
         end
         e = expected_records.pop_front();
         if (k != e.kind) begin
            $display("%0t: record_kind expected %0d, got %0d", $time, e.kind, k);
            errors++;
         end
         if (v != e.value) begin
            $display("%0t: record_value expected %h, got %h", $time, e.value, v);
            errors++;
         end
         if (f != e.bus) begin
            $display("%0t: bus_frequency expected %h, got %h", $time, e.bus, f);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_records.size();
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [7:0]  csr_wdata = '0;

   record_tracker_type tracker = new();

   // Byte stream waiting to be sent: bit 8 is image_start, bits 7:0 the byte.
   logic [8:0] beat_q[$];
   bit         next_first = 0;
   int         bytes_taken = 0;
   int         sender_idle = 27;
   int         receiver_idle = 69;
   bit         hold_request = 0;

   eeprom_board_record_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Global watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TEST FAILED");
      $finish;
   end

   // Every output beat is compared with the oldest predicted record. Sampling
   // happens at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_record(rsp_tuser, rsp_tdata[47:0], rsp_tdata[79:48]);
      end
   end

   // Receiver: stalls at random at the current rate. A hold request, seen at a
   // rising edge, turns into a long stall counted here so the block backs up.
   initial begin
      bit hold_seen;
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         hold_seen = hold_request;
         @(negedge clock);
         if (hold_seen) begin
            hold_request = 0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= receiver_idle);
         end
      end
   end

   // Queues a byte; the first byte of an image carries image_start, and now and
   // then a byte in the middle of an image does too.
   function automatic void add(logic [7:0] b);
      bit start;
      start = next_first || ($urandom_range(0, 299) == 0);
      beat_q.push_back({start, b});
      next_first = 0;
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add(s[i]);
   endfunction

   // Any byte that does not end a record.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == BYTE_NL || b == BYTE_FF) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [7:0] hex_char();
      case ($urandom_range(0, 2))
         0: return 8'(CHAR_ZERO + $urandom_range(0, 9));
         1: return 8'(CHAR_A + $urandom_range(0, 5));
         default: return 8'(CHAR_LOWER_A + $urandom_range(0, 5));
      endcase
   endfunction

   // Decimal digits, with the odd non-digit that still counts as a digit.
   function automatic void add_digits(int n);
      repeat (n) begin
         if ($urandom_range(0, 14) == 0) add(plain_byte());
         else add(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void add_tag(int k);
      case (k)
         0: begin add(CHAR_E); add(CHAR_A); end
         1: begin add(CHAR_S); add(CHAR_B); end
         2: begin add(CHAR_D); add(CHAR_ONE); end
         default: begin add(CHAR_H); add(CHAR_Z); end
      endcase
   endfunction

   // One record of random content: mostly well formed, some broken or noise.
   function automatic void add_record();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         add_tag(0);
         add(plain_byte());
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 12;
         repeat (n) add(($urandom_range(0, 9) == 0) ? plain_byte() : hex_char());
      end else if (pick < 45) begin
         add_tag((pick < 33) ? 1 : 2);
         add(plain_byte());
         add_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 12)
                                                : $urandom_range(1, 6));
      end else if (pick < 72) begin
         add_tag(3);
         add(plain_byte());
         // A slash as the first value byte is just another digit.
         if ($urandom_range(0, 9) == 0) add(BYTE_SLASH);
         add_digits(($urandom_range(0, 4) == 0) ? $urandom_range(0, 11)
                                                : $urandom_range(1, 3));
         if ($urandom_range(0, 2) != 0) begin
            add(BYTE_SLASH);
            case ($urandom_range(0, 5))
               0: ;                      // the terminator takes the denominator's place
               1: add(plain_byte());
               default: add(8'(CHAR_ZERO + $urandom_range(0, 9)));
            endcase
            repeat ($urandom_range(0, 2)) add(plain_byte());
         end
      end else if (pick < 86) begin
         // Unknown tags and records cut short inside their tag or at the separator.
         case ($urandom_range(0, 2))
            0: add(plain_byte());
            1: begin
               case ($urandom_range(0, 3))
                  0: add(CHAR_E);
                  1: add(CHAR_S);
                  2: add(CHAR_D);
                  default: add(CHAR_H);
               endcase
               if ($urandom_range(0, 1) == 0) add(plain_byte());
            end
            default: begin
               add_tag($urandom_range(0, 3));
               if ($urandom_range(0, 1) == 0) add(plain_byte());
            end
         endcase
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(0, 5)) add(plain_byte());
      end else begin
         repeat ($urandom_range(0, 8)) add(plain_byte());
      end
      add(($urandom_range(0, 9) == 0) ? BYTE_FF : BYTE_NL);
   endfunction

   // A whole image: a few records and, usually, the end-of-table mark with some
   // trailing bytes that the block must ignore.
   function automatic void add_image();
      next_first = 1;
      repeat ($urandom_range(1, 10)) add_record();
      if ($urandom_range(0, 3) != 0) begin
         add(($urandom_range(0, 1) == 0) ? BYTE_NUL : BYTE_FF);
         repeat ($urandom_range(0, 3)) add(8'($urandom_range(0, 255)));
      end
   endfunction

   // Offers one beat after a random gap and waits for it to be taken. Entered
   // and left just after a falling edge.
   task automatic send_byte(logic [7:0] b, bit start);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= b;
      req_tuser <= start;
      do @(posedge clock); while (!req_tready);
      if (tracker.take_byte(b, start)) bytes_taken++;
      @(negedge clock);
   endtask

   task automatic send_queued();
      logic [8:0] beat;
      while (beat_q.size() > 0) begin
         beat = beat_q.pop_front();
         send_byte(beat[7:0], beat[8]);
      end
   endtask

   // Stops offering beats until every predicted record has arrived, then gives
   // a divided clock record time to finish.
   task automatic quiesce();
      req_tvalid <= 0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_limit(logic [7:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      tracker.bus_limit = v;
   endtask

   // One idling regime; the limit changes at each chunk while the block is idle.
   task automatic run_phase(int s_idle, int r_idle, logic [7:0] first_limit, bit hold);
      int start_count;
      sender_idle = s_idle;
      receiver_idle = r_idle;
      for (int chunk = 0; chunk < 3; chunk++) begin
         quiesce();
         write_limit((chunk == 0) ? first_limit : 8'($urandom_range(0, 255)));
         if (hold && chunk == 0) hold_request = 1;
         start_count = bytes_taken;
         while (bytes_taken - start_count < CHUNK_BYTES) begin
            add_image();
            send_queued();
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed image at the reset limit of 50: rounding to a denominator,
      // missing hex digits, an empty value after the tag, an unknown tag, a bad
      // denominator with a halved bus, 0xFF as terminator, the end of the table
      // and a byte after it that is ignored.
      next_first = 1;
      add_text("HZ=9/4\n");
      add_text("EA Ff\n");
      add_text("SB\n");
      add_text("D1 9\n");
      add_text("X\n");
      add_text("HZ 300/x");
      add(BYTE_FF);
      add(BYTE_NUL);
      add(BYTE_FF);
      send_queued();

      run_phase(27, 69, 8'd0, 0);
      run_phase(69, 27, 8'd255, 0);
      run_phase(0, 0, 8'($urandom_range(1, 254)), 1);

      req_tvalid <= 0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
